// ===== rtl/b2s_pkg.sv =====
// shared types, constants and tables for the blake2s stream hasher
`default_nettype none
package b2s_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int ROUND_COUNT = 10;
   localparam int FILL_W      = 7;
   localparam int CSR_IDX_W   = 3;

   localparam logic [31:0] PARAM_WORD = 32'h0101_0020;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3 = 3'd4;

   localparam logic KIND_ABSORB = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [3:0] SIGMA [ROUND_COUNT][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

   // working vector indexes a, b, c, d of each mixing step
   localparam logic [15:0] G_INDEX [8] = '{
      {4'd0, 4'd4, 4'd8, 4'd12}, {4'd1, 4'd5, 4'd9, 4'd13},
      {4'd2, 4'd6, 4'd10, 4'd14}, {4'd3, 4'd7, 4'd11, 4'd15},
      {4'd0, 4'd5, 4'd10, 4'd15}, {4'd1, 4'd6, 4'd11, 4'd12},
      {4'd2, 4'd7, 4'd8, 4'd13}, {4'd3, 4'd4, 4'd9, 4'd14}
   };

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_OPEN     = 9'b000000100,
      S_LOAD     = 9'b000001000,
      S_ROUND    = 9'b000010000,
      S_FOLD     = 9'b000100000,
      S_EMIT_LO  = 9'b001000000,
      S_EMIT_HI  = 9'b010000000,
      S_EMIT_OUT = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/b2s_ram.sv =====
// generic single write, single registered read memory
`default_nettype none
module b2s_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/blake2s_stream_hasher.sv =====
// blake2s-256 stream hasher top level
//
// channel  direction  fields
// req      in         tdata: data_byte[7:0]; tuser: kind
// rsp      out        tdata: digest_word[63:0]; tuser: word_index; tlast: last_word
// csr      in         index: register number; data: register value
//
// an absorbed byte passes through dispatch back to idle; a byte that follows a full
// block adds a compression first (80 mixing steps on one adder pair)
// opening a message writes the key block and the initial chain into the memories
// a finish compresses the last block then emits four words, each held until taken
// reset is synchronous; no clearing pass, memories are written on message open
`default_nettype none
module blake2s_stream_hasher (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [7:0]                       req_tdata,   // data_byte
   input  wire logic                             req_tuser,   // kind
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [63:0]                      rsp_tdata,   // digest_word
   output      logic [1:0]                       rsp_tuser,   // word_index
   output      logic                             rsp_tlast,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [b2s_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [63:0]                      csr_data
);
   import b2s_pkg::*;

   state_type state_ff, state_in;
   logic [5:0]  key_len_ff;
   logic [63:0] key_ff [4];
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        open_ff, open_in;
   logic        final_ff, final_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic [2:0]  g_ff, g_in;
   logic [1:0]  ph_ff, ph_in;
   logic [3:0]  midx_ff, midx_in;
   logic [31:0] v_ff [16];
   logic [31:0] v_in [16];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  k_ff, k_in;

   logic        buf_we, buf_re, ch_we, ch_re;
   logic [3:0]  buf_wa, buf_ra;
   logic [2:0]  ch_wa, ch_ra;
   logic [31:0] buf_wd, buf_rd, ch_wd, ch_rd;

   logic [5:0]  klen;
   logic [31:0] key_half, key_masked, m_word, a_new, c_new, x_ad, x_bc;
   logic [15:0] gi;
   logic [3:0]  ia, ib, ic, id, nrnd;
   logic [1:0]  lane;
   logic [2:0]  ngidx;
   logic [4:0]  pos_word;

   b2s_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_en(buf_re), .rd_addr(buf_ra), .rd_data(buf_rd)
   );

   b2s_ram #(.WIDTH(32), .DEPTH(8)) u_chain (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd),
      .rd_en(ch_re), .rd_addr(ch_ra), .rd_data(ch_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = k_ff;
   assign rsp_tlast  = (k_ff == 2'd3);

   always_comb begin
      klen = (key_len_ff > 6'd32) ? 6'd32 : key_len_ff;
      key_half = cnt_ff[0] ? key_ff[cnt_ff[2:1]][63:32] : key_ff[cnt_ff[2:1]][31:0];
      for (int b = 0; b < 4; b++) begin
         key_masked[b*8 +: 8] = ({1'b0, cnt_ff[2:0], 2'(b)} < klen && !cnt_ff[3])
            ? key_half[b*8 +: 8] : 8'd0;
      end
      gi = G_INDEX[g_ff];
      ia = gi[15:12];
      ib = gi[11:8];
      ic = gi[7:4];
      id = gi[3:0];
      m_word = ({1'b0, midx_ff, 2'b00} >= fill_ff) ? 32'd0 : buf_rd;
      a_new = v_ff[ia] + v_ff[ib] + m_word;
      c_new = v_ff[ic] + v_ff[id];
      x_ad = v_ff[id] ^ a_new;
      x_bc = v_ff[ib] ^ c_new;
      nrnd = (g_ff == 3'd7) ? ((rnd_ff == 4'(ROUND_COUNT - 1)) ? 4'd0 : rnd_ff + 4'd1)
                            : rnd_ff;
      ngidx = g_ff + 3'd1;
      lane = fill_ff[1:0];
      pos_word = fill_ff[6:2];
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      byte_in = byte_ff;
      open_in = open_ff;
      final_in = final_ff;
      fill_in = fill_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      rnd_in = rnd_ff;
      g_in = g_ff;
      ph_in = ph_ff;
      midx_in = midx_ff;
      v_in = v_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      k_in = k_ff;
      buf_we = 1'b0;
      buf_wa = pos_word[3:0];
      buf_wd = 32'd0;
      buf_re = 1'b0;
      buf_ra = midx_ff;
      ch_we = 1'b0;
      ch_wa = cnt_ff[2:0];
      ch_wd = 32'd0;
      ch_re = 1'b0;
      ch_ra = cnt_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               byte_in = req_tdata;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cnt_in = 5'd0;
            if (!open_ff) begin
               state_in = S_OPEN;
            end else if (kind_ff == KIND_FINISH) begin
               count_in = count_ff + 64'(fill_ff);
               final_in = 1'b1;
               state_in = S_LOAD;
            end else if (fill_ff == FILL_W'(BLOCK_BYTES)) begin
               count_in = count_ff + 64'(BLOCK_BYTES);
               final_in = 1'b0;
               state_in = S_LOAD;
            end else begin
               acc_in = ((lane == 2'd0) ? 32'd0 : acc_ff) | (32'(byte_ff) << {lane, 3'b000});
               buf_we = 1'b1;
               buf_wd = acc_in;
               fill_in = fill_ff + 7'd1;
               state_in = S_IDLE;
            end
         end
         S_OPEN: begin
            buf_we = 1'b1;
            buf_wa = cnt_ff[3:0];
            buf_wd = key_masked;
            ch_we = !cnt_ff[3];
            ch_wd = IV_WORDS[cnt_ff[2:0]] ^
                    ((cnt_ff[2:0] == 3'd0) ? (PARAM_WORD ^ (32'(klen) << 8)) : 32'd0);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               open_in = 1'b1;
               count_in = 64'd0;
               fill_in = (klen != 6'd0) ? FILL_W'(BLOCK_BYTES) : 7'd0;
               state_in = S_DISPATCH;
            end
         end
         S_LOAD: begin
            ch_re = !cnt_ff[3];
            if (cnt_ff == 5'd0) begin
               for (int i = 0; i < 8; i++) begin
                  v_in[i + 8] = IV_WORDS[i];
               end
               v_in[12] = IV_WORDS[4] ^ count_ff[31:0];
               v_in[13] = IV_WORDS[5] ^ count_ff[63:32];
               v_in[14] = final_ff ? ~IV_WORDS[6] : IV_WORDS[6];
            end else begin
               v_in[4'(cnt_ff - 5'd1)] = ch_rd;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd8) begin
               buf_re = 1'b1;
               buf_ra = SIGMA[0][0];
               midx_in = SIGMA[0][0];
               rnd_in = 4'd0;
               g_in = 3'd0;
               ph_in = 2'd0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            ph_in = ph_ff + 2'd1;
            if (!ph_ff[0]) begin
               v_in[ia] = a_new;
               v_in[id] = ph_ff[1] ? {x_ad[7:0], x_ad[31:8]} : {x_ad[15:0], x_ad[31:16]};
            end else begin
               v_in[ic] = c_new;
               v_in[ib] = ph_ff[1] ? {x_bc[6:0], x_bc[31:7]} : {x_bc[11:0], x_bc[31:12]};
            end
            if (ph_ff == 2'd0) begin
               buf_re = 1'b1;
               buf_ra = SIGMA[rnd_ff][{g_ff, 1'b1}];
               midx_in = buf_ra;
            end
            if (ph_ff == 2'd3) begin
               buf_re = 1'b1;
               buf_ra = SIGMA[nrnd][{ngidx, 1'b0}];
               midx_in = buf_ra;
               g_in = ngidx;
               rnd_in = nrnd;
               if (g_ff == 3'd7 && rnd_ff == 4'(ROUND_COUNT - 1)) begin
                  cnt_in = 5'd0;
                  state_in = S_FOLD;
               end
            end
         end
         S_FOLD: begin
            ch_re = !cnt_ff[3];
            if (cnt_ff != 5'd0) begin
               ch_we = 1'b1;
               ch_wa = 3'(cnt_ff - 5'd1);
               ch_wd = ch_rd ^ v_ff[{1'b0, ch_wa}] ^ v_ff[{1'b1, ch_wa}];
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd8) begin
               fill_in = 7'd0;
               if (final_ff) begin
                  open_in = 1'b0;
                  count_in = 64'd0;
                  k_in = 2'd0;
                  state_in = S_EMIT_LO;
               end else begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_EMIT_LO: begin
            ch_re = 1'b1;
            ch_ra = {k_ff, 1'b0};
            state_in = S_EMIT_HI;
         end
         S_EMIT_HI: begin
            ch_re = 1'b1;
            ch_ra = {k_ff, 1'b1};
            rsp_data_in[31:0] = ch_rd;
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_data_in[63:32] = ch_rd;
               rsp_valid_in = 1'b1;
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = S_EMIT_LO;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         key_len_ff <= 6'd0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= 64'd0;
         end
         open_ff <= 1'b0;
         fill_ff <= 7'd0;
         count_ff <= 64'd0;
         rsp_valid_ff <= 1'b0;
         k_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         open_ff <= open_in;
         fill_ff <= fill_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff <= k_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_KEY_LENGTH: key_len_ff <= csr_data[5:0];
               CSR_KEY_WORD_0: key_ff[0] <= csr_data;
               CSR_KEY_WORD_1: key_ff[1] <= csr_data;
               CSR_KEY_WORD_2: key_ff[2] <= csr_data;
               CSR_KEY_WORD_3: key_ff[3] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      final_ff <= final_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      rnd_ff <= rnd_in;
      g_ff <= g_in;
      ph_ff <= ph_in;
      midx_ff <= midx_in;
      v_ff <= v_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the blake2s stream hasher: directed and random messages
`default_nettype none

typedef struct {
   logic [63:0] digest;
   logic [1:0]  index;
   logic        last;
} digest_word_type;

class digest_scoreboard;
   logic [5:0]  key_len;
   logic [63:0] key_word [4];
   logic [31:0] chain [8];
   logic [31:0] block [16];
   logic [31:0] work [16];
   int          fill;
   logic [63:0] count;
   bit          msg_open;
   digest_word_type pending [$];
   int          errors;

   function new();
      key_len = 0;
      foreach (key_word[i]) key_word[i] = 0;
      fill = 0;
      count = 0;
      msg_open = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [b2s_pkg::CSR_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
         b2s_pkg::CSR_KEY_LENGTH: key_len = data[5:0];
         b2s_pkg::CSR_KEY_WORD_0: key_word[0] = data;
         b2s_pkg::CSR_KEY_WORD_1: key_word[1] = data;
         b2s_pkg::CSR_KEY_WORD_2: key_word[2] = data;
         b2s_pkg::CSR_KEY_WORD_3: key_word[3] = data;
         default: ;
      endcase
   endfunction

   function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function void mix(int a, int b, int c, int d, logic [31:0] x, logic [31:0] y);
      work[a] = work[a] + work[b] + x;
      work[d] = rotr(work[d] ^ work[a], 16);
      work[c] = work[c] + work[d];
      work[b] = rotr(work[b] ^ work[c], 12);
      work[a] = work[a] + work[b] + y;
      work[d] = rotr(work[d] ^ work[a], 8);
      work[c] = work[c] + work[d];
      work[b] = rotr(work[b] ^ work[c], 7);
   endfunction

   function void compress(bit final_blk);
      for (int i = 0; i < 8; i++) begin
         work[i] = chain[i];
         work[i+8] = b2s_pkg::IV_WORDS[i];
      end
      work[12] ^= count[31:0];
      work[13] ^= count[63:32];
      if (final_blk) work[14] = ~work[14];
      for (int r = 0; r < b2s_pkg::ROUND_COUNT; r++) begin
         for (int g = 0; g < 8; g++) begin
            mix(b2s_pkg::G_INDEX[g][15:12], b2s_pkg::G_INDEX[g][11:8],
                b2s_pkg::G_INDEX[g][7:4], b2s_pkg::G_INDEX[g][3:0],
                block[b2s_pkg::SIGMA[r][2*g]], block[b2s_pkg::SIGMA[r][2*g+1]]);
         end
      end
      for (int i = 0; i < 8; i++) chain[i] ^= work[i] ^ work[i+8];
   endfunction

   function void open_message();
      int k;
      k = (key_len > 32) ? 32 : key_len;
      for (int i = 0; i < 8; i++) chain[i] = b2s_pkg::IV_WORDS[i];
      chain[0] ^= b2s_pkg::PARAM_WORD ^ (k << 8);
      foreach (block[i]) block[i] = 0;
      count = 0;
      fill = 0;
      if (k != 0) begin
         for (int i = 0; i < k; i++)
            block[i>>2][(i%4)*8 +: 8] = key_word[i>>3][(i%8)*8 +: 8];
         fill = b2s_pkg::BLOCK_BYTES;
      end
      msg_open = 1;
   endfunction

   function void note_item(logic kind, logic [7:0] data);
      digest_word_type w;
      if (!msg_open) open_message();
      if (kind == b2s_pkg::KIND_ABSORB) begin
         if (fill >= b2s_pkg::BLOCK_BYTES) begin
            count += 64'(b2s_pkg::BLOCK_BYTES);
            compress(0);
            fill = 0;
         end
         block[fill>>2][(fill%4)*8 +: 8] = data;
         fill++;
      end else begin
         count += 64'(fill);
         for (int i = fill; i < b2s_pkg::BLOCK_BYTES; i++) block[i>>2][(i%4)*8 +: 8] = 0;
         compress(1);
         for (int k = 0; k < 4; k++) begin
            w.digest = {chain[2*k+1], chain[2*k]};
            w.index = 2'(k);
            w.last = (k == 3);
            pending.push_back(w);
         end
         msg_open = 0;
         fill = 0;
         count = 0;
      end
   endfunction

   function void check_word(logic [63:0] digest, logic [1:0] index, logic last);
      digest_word_type w;
      if (pending.size() == 0) begin
         $display("%0t unexpected digest word %h", $time, digest);
         errors++;
         return;
      end
      w = pending.pop_front();
      if (digest !== w.digest) begin
         $display("%0t digest_word exp %h got %h", $time, w.digest, digest);
         errors++;
      end
      if (index !== w.index) begin
         $display("%0t word_index exp %0d got %0d", $time, w.index, index);
         errors++;
      end
      if (last !== w.last) begin
         $display("%0t last_word exp %0d got %0d", $time, w.last, last);
         errors++;
      end
   endfunction
endclass

module tb;
   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [7:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid, csr_ready;
   logic [b2s_pkg::CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_data;

   digest_scoreboard sb;
   int  items_sent;
   bit  no_gaps;
   bit  more_msgs;
   int  quiet_cycles;

   blake2s_stream_hasher DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = 0;
      rsp_tready = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("blake2s_stream_hasher regression: fail");
         $finish;
      end
   end

   function int pick_gap();
      if (no_gaps) return 0;
      if ($urandom_range(15) == 0) return $urandom_range(60, 20);
      return $urandom_range(2);
   endfunction

   initial begin
      bit held;
      int gap;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && items_sent >= 100 && more_msgs && req_tvalid) begin
            held = 1;
            rsp_tready <= 0;
            repeat (2500) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(logic kind, logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) send_item(b2s_pkg::KIND_ABSORB, 8'($urandom_range(255)));
      send_item(b2s_pkg::KIND_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [b2s_pkg::CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_key(logic [5:0] len, logic [63:0] w0, logic [63:0] w1,
                          logic [63:0] w2, logic [63:0] w3);
      csr_write(b2s_pkg::CSR_KEY_LENGTH, 64'(len));
      csr_write(b2s_pkg::CSR_KEY_WORD_0, w0);
      csr_write(b2s_pkg::CSR_KEY_WORD_1, w1);
      csr_write(b2s_pkg::CSR_KEY_WORD_2, w2);
      csr_write(b2s_pkg::CSR_KEY_WORD_3, w3);
   endtask

   initial begin
      int len, sel, nmsg;
      logic [5:0] klen;
      sb = new();
      items_sent = 0;
      no_gaps = 0;
      more_msgs = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty message, then a short one with extreme bytes
      send_item(b2s_pkg::KIND_FINISH, 8'h00);
      send_item(b2s_pkg::KIND_ABSORB, 8'h00);
      send_item(b2s_pkg::KIND_ABSORB, 8'hFF);
      send_item(b2s_pkg::KIND_FINISH, 8'hFF);
      wait_idle();
      // full key of all ones: key block alone, then key block plus one byte
      set_key(6'd32, '1, '1, '1, '1);
      send_item(b2s_pkg::KIND_FINISH, 8'h00);
      send_item(b2s_pkg::KIND_ABSORB, 8'hA5);
      send_item(b2s_pkg::KIND_FINISH, 8'h00);
      wait_idle();
      // oversized key length, clamped to a full key
      set_key(6'd63, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, '0, 64'h8000000000000001);
      send_item(b2s_pkg::KIND_ABSORB, 8'h5A);
      send_item(b2s_pkg::KIND_FINISH, 8'h00);
      wait_idle();
      // short key with junk bytes above its length, ignored register indexes
      set_key(6'd5, '1, '1, '1, '1);
      csr_write(3'd7, '1);
      csr_write(3'd5, 64'h0);
      send_item(b2s_pkg::KIND_FINISH, 8'h00);
      send_item(b2s_pkg::KIND_ABSORB, 8'h3C);
      send_item(b2s_pkg::KIND_FINISH, 8'h00);
      wait_idle();

      while (items_sent < 320) begin
         sel = $urandom_range(5);
         klen = (sel == 0) ? 6'd0 : (sel == 1) ? 6'd32 : (sel == 2) ? 6'd63
              : 6'($urandom_range(40));
         set_key(klen, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
         if ($urandom_range(3) == 0)
            csr_write(3'($urandom_range(7, 5)), {$urandom, $urandom});
         no_gaps = ($urandom_range(3) == 0);
         nmsg = $urandom_range(4, 2);
         for (int m = 0; m < nmsg; m++) begin
            sel = $urandom_range(9);
            if (sel == 0) len = 64;
            else if (sel == 1) len = $urandom_range(1) ? 63 : 65;
            else if (sel == 2) len = $urandom_range(130, 100);
            else len = $urandom_range(20);
            if (items_sent < 320) begin
               if (len > 319 - items_sent) len = 319 - items_sent;
               more_msgs = (m < nmsg - 1);
               send_message(len);
            end
         end
         more_msgs = 0;
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("blake2s_stream_hasher regression: pass");
      else
         $display("blake2s_stream_hasher regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/b2s_pkg.sv
rtl/b2s_ram.sv
rtl/blake2s_stream_hasher.sv
verif/tb.sv
